>>> hdl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared codes and the control/status bundles for the dual stack buffer.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Width of the external value fields.
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;        // write the input value and grow the stack
        logic pop_start;   // shrink the stack and read its top entry
        logic dump_start;  // read the bottom entry of the stack
        logic step;        // read the next entry of a dump
        logic load_err;    // load an error beat into the output register
        logic load_ok;     // load a plain success beat
        logic load_data;   // load a beat carrying the read data
    } dss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // the two stacks meet
        logic empty;       // the selected stack holds nothing
        logic at_end;      // the pending read is the final one
        logic out_free;    // the output register can take a beat
    } dss_stat_t;

endpackage

>>> hdl/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/dss_datapath.sv
// ----------------------------------------------------------------------------
// dss_datapath
// Stack counts, read sequencing, shared element store and output register.
// ----------------------------------------------------------------------------
module dss_datapath
    import dss_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dss_cmd_t                  cmd,
    output dss_stat_t                 stat,
    input  logic                      stack_select,
    input  logic signed [VALUE_W-1:0] push_value,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic                      status,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] end_reg, end_next;
    logic          sel_reg, sel_next;
    logic          out_valid_reg, out_valid_next;
    logic          status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic          last_reg;

    logic [CW-1:0]     sel_count;
    logic [CW:0]       count_sum;
    logic [AW-1:0]     top_idx;
    logic [AW-1:0]     wr_addr;
    logic [63:0]       push_wide;
    logic [DATA_WIDTH-1:0] wr_data;
    logic              rd_en;
    logic              rd_sel;
    logic [AW-1:0]     rd_idx;
    logic [AW-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [63:0]       rd_wide;
    logic              out_free;

    // Status toward the controller.
    assign sel_count = stack_select ? second_count_reg : first_count_reg;
    assign count_sum = {1'b0, first_count_reg} + {1'b0, second_count_reg};
    assign top_idx   = AW'(sel_count - CW'(1));
    assign out_free  = !out_valid_reg || !out_stall;

    assign stat.full     = (count_sum >= (CW + 1)'(DEPTH));
    assign stat.empty    = (sel_count == '0);
    assign stat.at_end   = (idx_reg == end_reg);
    assign stat.out_free = out_free;

    // Write side: the first stack grows up from entry zero, the second down
    // from the top entry.
    assign push_wide = 64'($unsigned(push_value));
    assign wr_data   = push_wide[DATA_WIDTH-1:0];
    assign wr_addr   = stack_select ? (TOP_ADDR - second_count_reg[AW-1:0])
                                    : first_count_reg[AW-1:0];

    // Read side: a pop reads the top entry, a dump walks up from the bottom.
    assign rd_en  = cmd.pop_start || cmd.dump_start || cmd.step;
    assign rd_sel = (cmd.pop_start || cmd.dump_start) ? stack_select : sel_reg;

    always_comb
    begin
        rd_idx = idx_reg + AW'(1);
        if (cmd.pop_start)
        begin
            rd_idx = top_idx;
        end
        else if (cmd.dump_start)
        begin
            rd_idx = '0;
        end
    end

    assign rd_addr = rd_sel ? (TOP_ADDR - rd_idx) : rd_idx;

    dss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_wide = 64'(rd_data);

    // Count and sequencing updates.
    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        idx_next          = idx_reg;
        end_next          = end_reg;
        sel_next          = sel_reg;
        if (cmd.push)
        begin
            if (stack_select)
            begin
                second_count_next = second_count_reg + CW'(1);
            end
            else
            begin
                first_count_next = first_count_reg + CW'(1);
            end
        end
        if (cmd.pop_start)
        begin
            if (stack_select)
            begin
                second_count_next = second_count_reg - CW'(1);
            end
            else
            begin
                first_count_next = first_count_reg - CW'(1);
            end
            idx_next = top_idx;
            end_next = top_idx;
            sel_next = stack_select;
        end
        if (cmd.dump_start)
        begin
            idx_next = '0;
            end_next = top_idx;
            sel_next = stack_select;
        end
        if (cmd.step)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            idx_reg          <= '0;
            end_reg          <= '0;
            sel_reg          <= 1'b0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            idx_reg          <= idx_next;
            end_reg          <= end_next;
            sel_reg          <= sel_next;
        end
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_err || cmd.load_ok || cmd.load_data)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload; errors and push results carry a zero value.
    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            status_reg    <= STATUS_ERR;
            out_value_reg <= '0;
            last_reg      <= 1'b1;
        end
        else if (cmd.load_ok)
        begin
            status_reg    <= STATUS_OK;
            out_value_reg <= '0;
            last_reg      <= 1'b1;
        end
        else if (cmd.load_data)
        begin
            status_reg    <= STATUS_OK;
            out_value_reg <= rd_wide[VALUE_W-1:0];
            last_reg      <= stat.at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_value = $signed(out_value_reg);
    assign last      = last_reg;

endmodule

>>> hdl/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl
// Command decoder and sequencer for pops and dumps.
// ----------------------------------------------------------------------------
module dss_ctrl
    import dss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CMD_W-1:0] command,
    input  dss_stat_t        stat,
    output dss_cmd_t         cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg, state_next;
    logic accept;

    assign in_stall = !((state_reg == ST_IDLE) && stat.out_free);
    assign accept   = in_valid && !in_stall;

    // Decode accepted commands and sequence reads until the final beat.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_PUSH:
                        begin
                            if (stat.full)
                            begin
                                cmd.load_err = 1'b1;
                            end
                            else
                            begin
                                cmd.push    = 1'b1;
                                cmd.load_ok = 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_err = 1'b1;
                            end
                            else
                            begin
                                cmd.pop_start = 1'b1;
                                state_next    = ST_READ;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_err = 1'b1;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                state_next     = ST_READ;
                            end
                        end
                        default:
                        begin
                            cmd.load_err = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.load_data = 1'b1;
                    if (stat.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/dual_stack_shared_buffer.sv
// A push or any error gives its result beat in the cycle after acceptance; a
// pop's beat goes from the registered store read to the output register. A
// push is taken 1 item per cycle while the output is not stalled; a pop or dump
// takes no new item until its last beat is loaded, a dump of N elements streams
// one beat per cycle while unstalled, all via the store's single registered read port.
// Reset clears both stack counts and the output valid flag, not the store or payload.
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer
// Two LIFO stacks sharing one element store, growing from opposite ends.
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer
    import dss_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CMD_W-1:0]          command,
    input  logic                      stack_select,
    input  logic signed [VALUE_W-1:0] push_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      status,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      last
);

    dss_cmd_t  cmd;
    dss_stat_t stat;

    // Sequencer.
    dss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Counts, store and output register.
    dss_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .stack_select (stack_select),
        .push_value   (push_value),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .out_value    (out_value),
        .last         (last)
    );

endmodule

>>> hdl/dss_checker.sv
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks on the dual stack buffer, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker
    import dss_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [CMD_W-1:0]          command,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      status,
    input logic signed [VALUE_W-1:0] out_value,
    input logic                      last
);

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(out_value) && $stable(last))
        else $error("output beat changed while stalled");

    // An error beat carries a zero value and ends its item.
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_ERR) |-> (out_value == '0) && last)
        else $error("error beat with value or without last");

    // An accepted push answers in the next cycle with a single zero beat.
    a_push_resp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_PUSH)
            |=> out_valid && last && (out_value == '0))
        else $error("push result missing or malformed");

    // No new item is taken while a dump still has beats to deliver.
    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input accepted in the middle of a dump");

endmodule

bind dual_stack_shared_buffer dss_checker u_dss_checker (.*);

>>> dv/dual_stack_shared_buffer_test.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer_test
// Drives push, pop and dump commands into the dual stack buffer and checks
// every output beat against a scoreboard predicted from a shadow copy of
// both stacks. Both handshakes see random stall and idle bursts.
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int ITEM_TARGET = 430;
    localparam int TAIL_ITEMS  = 40;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AFTER  = 80;

    // Code three is not a command; the block answers it with an error beat.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               sel;
        logic [VALUE_W-1:0] value;
        logic               drain_first;
    } stack_op_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] value;
        logic               last;
    } result_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [CMD_W-1:0]          command = CMD_PUSH;
    logic                      stack_select = 1'b0;
    logic signed [VALUE_W-1:0] push_value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      status;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;

    // Commands waiting to be sent, and beats the block still owes us.
    stack_op_t    cmd_backlog[$];
    result_beat_t awaited_beats[$];

    // Shadow copy of the shared store and both stack heights.
    logic [VALUE_W-1:0] shadow_store[STACK_DEPTH];
    int                 low_height  = 0;
    int                 high_height = 0;

    // Heights as the stimulus generator sees them, to shape sequences.
    int gen_low  = 0;
    int gen_high = 0;

    stack_op_t cur_op;
    int        send_gap     = 0;
    int        stall_left   = 0;
    int        hold_left    = 0;
    bit        hold_done    = 1'b0;
    bit        quiet_tail   = 1'b0;
    int        accepted_cnt = 0;
    int        error_cnt    = 0;

    dual_stack_shared_buffer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .stack_select (stack_select),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_value    (out_value),
        .last         (last)
    );

    always #10 clk = ~clk;

    function automatic result_beat_t make_beat(logic st, logic [VALUE_W-1:0] v, logic lst);
        result_beat_t b;
        b.status = st;
        b.value  = v;
        b.last   = lst;
        return b;
    endfunction

    // Apply one accepted command to the shadow stacks and queue its beats.
    function automatic void apply_stack_command(stack_op_t op);
        int height;
        height = op.sel ? high_height : low_height;
        case (op.cmd)
            CMD_PUSH:
            begin
                if (low_height + high_height >= STACK_DEPTH)
                begin
                    awaited_beats.push_back(make_beat(STATUS_ERR, '0, 1'b1));
                end
                else
                begin
                    if (op.sel)
                    begin
                        shadow_store[STACK_DEPTH - 1 - high_height] = op.value;
                        high_height++;
                    end
                    else
                    begin
                        shadow_store[low_height] = op.value;
                        low_height++;
                    end
                    awaited_beats.push_back(make_beat(STATUS_OK, '0, 1'b1));
                end
            end
            CMD_POP:
            begin
                if (height == 0)
                begin
                    awaited_beats.push_back(make_beat(STATUS_ERR, '0, 1'b1));
                end
                else if (op.sel)
                begin
                    high_height--;
                    awaited_beats.push_back(make_beat(STATUS_OK,
                        shadow_store[STACK_DEPTH - 1 - high_height], 1'b1));
                end
                else
                begin
                    low_height--;
                    awaited_beats.push_back(make_beat(STATUS_OK,
                        shadow_store[low_height], 1'b1));
                end
            end
            CMD_DUMP:
            begin
                if (height == 0)
                begin
                    awaited_beats.push_back(make_beat(STATUS_ERR, '0, 1'b1));
                end
                else
                begin
                    // Bottom of the stack first, last marker on the top entry.
                    for (int i = 0; i < height; i++)
                    begin
                        awaited_beats.push_back(make_beat(STATUS_OK,
                            shadow_store[op.sel ? STACK_DEPTH - 1 - i : i],
                            (i == height - 1)));
                    end
                end
            end
            default:
            begin
                awaited_beats.push_back(make_beat(STATUS_ERR, '0, 1'b1));
            end
        endcase
    endfunction

    // Queue one command and track the heights it leaves behind.
    function automatic void queue_op(logic [CMD_W-1:0] cmd, logic sel,
                                     logic [VALUE_W-1:0] value, logic drain);
        stack_op_t op;
        op.cmd         = cmd;
        op.sel         = sel;
        op.value       = value;
        op.drain_first = drain;
        if (cmd == CMD_PUSH && gen_low + gen_high < STACK_DEPTH)
        begin
            if (sel)
                gen_high++;
            else
                gen_low++;
        end
        else if (cmd == CMD_POP)
        begin
            if (sel && gen_high > 0)
                gen_high--;
            else if (!sel && gen_low > 0)
                gen_low--;
        end
        cmd_backlog.push_back(op);
    endfunction

    // Random element, with the extremes of the range mixed in.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Sender: holds a beat while stalled, otherwise offers the next command.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_stack_command(cur_op);
                accepted_cnt++;
            end
            quiet_tail <= (cmd_backlog.size() < TAIL_ITEMS);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog[0].drain_first && awaited_beats.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_op = cmd_backlog.pop_front();
                    command      <= cur_op.cmd;
                    stack_select <= cur_op.sel;
                    push_value   <= cur_op.value;
                    in_valid     <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 11);
                end
            end
        end
    end

    // Receiver stall: random bursts and one long hold-off, none at the tail.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge clk)
    begin
        result_beat_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_beats.size() == 0)
            begin
                $display("%0t: unexpected beat status %0d value %h last %0d",
                         $time, status, out_value, last);
                error_cnt++;
            end
            else
            begin
                exp_beat = awaited_beats.pop_front();
                if (status !== exp_beat.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, exp_beat.status, status);
                    error_cnt++;
                end
                if (out_value !== exp_beat.value)
                begin
                    $display("%0t: out_value expected %h got %h",
                             $time, exp_beat.value, out_value);
                    error_cnt++;
                end
                if (last !== exp_beat.last)
                begin
                    $display("%0t: last expected %0d got %0d",
                             $time, exp_beat.last, last);
                    error_cnt++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        bit pause_placed;
        int burst;
        pause_placed = 1'b0;

        // Empty stacks, the unused code, extreme values and short dumps.
        queue_op(CMD_POP,    1'b0, $urandom, 1'b0);
        queue_op(CMD_POP,    1'b1, $urandom, 1'b0);
        queue_op(CMD_DUMP,   1'b0, $urandom, 1'b0);
        queue_op(CMD_DUMP,   1'b1, $urandom, 1'b0);
        queue_op(CMD_UNUSED, 1'b0, $urandom, 1'b0);
        queue_op(CMD_PUSH,   1'b0, 32'h8000_0000, 1'b0);
        queue_op(CMD_PUSH,   1'b1, 32'h7fff_ffff, 1'b0);
        queue_op(CMD_PUSH,   1'b0, 32'h0000_0000, 1'b0);
        queue_op(CMD_PUSH,   1'b1, 32'hffff_ffff, 1'b0);
        queue_op(CMD_PUSH,   1'b0, 32'h0000_0001, 1'b0);
        queue_op(CMD_DUMP,   1'b0, $urandom, 1'b0);
        queue_op(CMD_DUMP,   1'b1, $urandom, 1'b0);
        queue_op(CMD_POP,    1'b0, $urandom, 1'b0);
        queue_op(CMD_POP,    1'b1, $urandom, 1'b0);
        queue_op(CMD_POP,    1'b1, $urandom, 1'b0);
        queue_op(CMD_POP,    1'b1, $urandom, 1'b0);
        queue_op(CMD_DUMP,   1'b1, $urandom, 1'b0);
        queue_op(CMD_UNUSED, 1'b1, 32'hffff_ffff, 1'b0);
        queue_op(CMD_POP,    1'b0, $urandom, 1'b0);
        queue_op(CMD_POP,    1'b0, $urandom, 1'b0);
        queue_op(CMD_POP,    1'b0, $urandom, 1'b0);

        // Random sequences; one item waits until the block has drained.
        while (cmd_backlog.size() < ITEM_TARGET)
        begin
            if (!pause_placed && cmd_backlog.size() >= ITEM_TARGET / 2)
            begin
                queue_op(CMD_DUMP, 1'($urandom_range(0, 1)), $urandom, 1'b1);
                pause_placed = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // Fill the store, then push into the full store.
                    while (gen_low + gen_high < STACK_DEPTH)
                        queue_op(CMD_PUSH, 1'($urandom_range(0, 1)), pick_value(), 1'b0);
                    repeat ($urandom_range(1, 3))
                        queue_op(CMD_PUSH, 1'($urandom_range(0, 1)), pick_value(), 1'b0);
                end
                2:
                begin
                    // Empty one stack and pop once more.
                    if ($urandom_range(0, 1))
                        burst = gen_high;
                    else
                        burst = -gen_low;
                    if (burst >= 0)
                        repeat (burst + 1) queue_op(CMD_POP, 1'b1, $urandom, 1'b0);
                    else
                        repeat (1 - burst) queue_op(CMD_POP, 1'b0, $urandom, 1'b0);
                end
                3:
                begin
                    queue_op(CMD_DUMP, 1'b0, $urandom, 1'b0);
                    queue_op(CMD_DUMP, 1'b1, $urandom, 1'b0);
                end
                4, 5, 6, 7:
                begin
                    // Mixed traffic, mostly pushes and pops.
                    repeat ($urandom_range(4, 12))
                    begin
                        burst = $urandom_range(0, 9);
                        if (burst < 5)
                            queue_op(CMD_PUSH, 1'($urandom_range(0, 1)), pick_value(),
                                     1'b0);
                        else if (burst < 8)
                            queue_op(CMD_POP, 1'($urandom_range(0, 1)), $urandom, 1'b0);
                        else
                            queue_op(CMD_DUMP, 1'($urandom_range(0, 1)), $urandom, 1'b0);
                    end
                end
                8:
                begin
                    // Noise: any code, any select, any value.
                    repeat ($urandom_range(1, 3))
                        queue_op(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 $urandom, 1'b0);
                end
                default:
                begin
                    repeat ($urandom_range(1, 8))
                        queue_op(CMD_POP, 1'($urandom_range(0, 1)), $urandom, 1'b0);
                end
            endcase
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || in_valid || awaited_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> dual_stack_shared_buffer.f
hdl/dss_pkg.sv
hdl/dss_ram.sv
hdl/dss_datapath.sv
hdl/dss_ctrl.sv
hdl/dual_stack_shared_buffer.sv
hdl/dss_checker.sv
dv/dual_stack_shared_buffer_test.sv
